>>> src/dfrq_pkg.sv
// Shared types and constants for the deferred release queue.
// No dependencies; imported by the sequencer and the top level.
package dfrq_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 6;
    localparam int FRM_W  = 32;
    localparam int HND_W  = 64;
    localparam int TYP_W  = 8;
    localparam int TOT_W  = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // request codes
    localparam logic [2:0] OP_QUEUE   = 3'd0;
    localparam logic [2:0] OP_COLLECT = 3'd1;
    localparam logic [2:0] OP_FLUSH   = 3'd2;
    localparam logic [2:0] OP_COUNT   = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    // configuration register indexes
    localparam logic CFG_DEFER = 1'b0;
    localparam logic CFG_CAP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME_SCAN,
        S_SCAN,
        S_PRIME_EMIT,
        S_EMIT,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [HND_W-1:0] handle;
        logic [TYP_W-1:0] rtype;
        logic [FRM_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic [FRM_W-1:0] defer;
        logic [CNT_W-1:0] cap;
    } t_cfg;

    typedef struct packed {
        logic             is_release;
        logic [HND_W-1:0] handle;
        logic             last;
        logic             flag;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] pending;
        logic [CNT_W-1:0] peak;
        logic [TOT_W-1:0] queued;
        logic [TOT_W-1:0] released;
    } t_result;

endpackage

>>> src/dfrq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module dfrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/dfrq_seq.sv
// Request sequencer: walks the entry RAM, keeps counters, holds the result register.
// Depends on dfrq_pkg.
module dfrq_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dfrq_pkg::t_cfg            i_cfg,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic [2:0]                i_op,
    input  logic [dfrq_pkg::HND_W-1:0] i_handle,
    input  logic [dfrq_pkg::TYP_W-1:0] i_res_type,
    input  logic [dfrq_pkg::FRM_W-1:0] i_frame,
    output dfrq_pkg::t_mem_wr         o_mem_wr,
    output logic [dfrq_pkg::ADDR_W-1:0] o_mem_raddr,
    input  dfrq_pkg::t_entry          i_mem_rdata,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output dfrq_pkg::t_result         o_res
);

    import dfrq_pkg::*;

    t_state           r_state, n_state;
    logic [2:0]       r_op;
    logic [HND_W-1:0] r_key_handle;
    logic [TYP_W-1:0] r_key_type;
    logic [FRM_W-1:0] r_frame;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_num;
    logic [CNT_W-1:0] r_keep;
    logic [CNT_W-1:0] r_cnt;
    logic             r_flag;
    logic [CNT_W-1:0] r_pending;
    logic [CNT_W-1:0] r_peak;
    logic [TOT_W-1:0] r_queued;
    logic [TOT_W-1:0] r_released;
    logic             r_ov;
    t_result          r_res;

    logic             accept;
    logic             in_range;
    logic             slot_free;
    logic             due;
    logic             go;
    logic             load_rel;
    logic             load_fin;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] ptr_next;
    logic [FRM_W-1:0] deadline;
    logic [CNT_W-1:0] pend_inc;

    assign accept    = i_req_valid && (r_state == S_IDLE);
    assign in_range  = r_ptr < r_num;
    assign slot_free = !r_ov || i_res_ready;
    assign lim       = (i_cfg.cap < DEPTH_CNT) ? i_cfg.cap : DEPTH_CNT;
    assign deadline  = i_mem_rdata.frame + i_cfg.defer;
    assign due       = (r_frame >= deadline) || (r_op == OP_FLUSH);
    assign ptr_next  = r_ptr + CNT_W'(1);
    assign pend_inc  = r_pending + CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_COLLECT, OP_COUNT, OP_LOOKUP: n_state = S_PRIME_SCAN;
                        OP_FLUSH:                        n_state = S_PRIME_EMIT;
                        default:                         n_state = S_FINAL;
                    endcase
                end
            end
            S_PRIME_SCAN: n_state = S_SCAN;
            S_SCAN: begin
                if (!in_range) begin
                    n_state = (r_op == OP_COLLECT) ? S_PRIME_EMIT : S_FINAL;
                end
            end
            S_PRIME_EMIT: n_state = S_EMIT;
            S_EMIT: begin
                if (!in_range) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        go             = 1'b0;
        load_rel       = 1'b0;
        load_fin       = 1'b0;
        o_mem_wr.we    = 1'b0;
        o_mem_wr.addr  = r_pending[ADDR_W-1:0];
        o_mem_wr.data  = '{handle: i_handle, rtype: i_res_type, frame: i_frame};
        o_mem_raddr    = '0;
        case (r_state)
            S_IDLE: begin
                o_mem_wr.we = accept && (i_op == OP_QUEUE) && (r_pending < lim);
            end
            S_SCAN: begin
                go          = in_range;
                o_mem_raddr = go ? ptr_next[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];
            end
            S_EMIT: begin
                // a released entry must wait for the result slot; survivors pack down
                go            = in_range && (!due || slot_free);
                load_rel      = in_range && due && slot_free;
                o_mem_wr.we   = in_range && !due;
                o_mem_wr.addr = r_keep[ADDR_W-1:0];
                o_mem_wr.data = i_mem_rdata;
                o_mem_raddr   = go ? ptr_next[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];
            end
            S_FINAL: begin
                load_fin = slot_free;
            end
            default: begin
                o_mem_raddr = '0;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ov       <= 1'b0;
            r_pending  <= '0;
            r_peak     <= '0;
            r_queued   <= '0;
            r_released <= '0;
        end else begin
            r_state <= n_state;

            if (load_rel || load_fin) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_op)
                            OP_QUEUE: begin
                                if (r_pending < lim) begin
                                    r_pending <= pend_inc;
                                    r_queued  <= r_queued + TOT_W'(1);
                                    if (pend_inc > r_peak) begin
                                        r_peak <= pend_inc;
                                    end
                                end
                            end
                            OP_FLUSH: begin
                                r_released <= r_released + TOT_W'(r_pending);
                                r_pending  <= '0;
                            end
                            OP_CLEAR: begin
                                r_pending  <= '0;
                                r_peak     <= '0;
                                r_queued   <= '0;
                                r_released <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // collect: totals settle before any release is shown
                    if (!in_range && (r_op == OP_COLLECT)) begin
                        r_pending  <= r_pending - r_cnt;
                        r_released <= r_released + TOT_W'(r_cnt);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op         <= i_op;
                    r_key_handle <= i_handle;
                    r_key_type   <= i_res_type;
                    r_frame      <= i_frame;
                    r_ptr        <= '0;
                    r_keep       <= '0;
                    r_num        <= r_pending;
                    r_cnt        <= (i_op == OP_FLUSH) ? r_pending : '0;
                    r_flag       <= (i_op == OP_QUEUE) && (r_pending < lim);
                end
            end
            S_PRIME_SCAN, S_PRIME_EMIT: begin
                r_ptr <= '0;
            end
            S_SCAN: begin
                if (in_range) begin
                    r_ptr <= ptr_next;
                    case (r_op)
                        OP_COLLECT: begin
                            if (due) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end
                        end
                        OP_COUNT: begin
                            if (i_mem_rdata.rtype == r_key_type) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            if (i_mem_rdata.handle == r_key_handle) begin
                                r_flag <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (go) begin
                    r_ptr <= ptr_next;
                    if (!due) begin
                        r_keep <= r_keep + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (load_rel || load_fin) begin
            r_res.is_release <= load_rel;
            r_res.handle     <= load_rel ? i_mem_rdata.handle : '0;
            r_res.last       <= load_fin;
            r_res.flag       <= r_flag;
            r_res.count      <= r_cnt;
            r_res.pending    <= r_pending;
            r_res.peak       <= r_peak;
            r_res.queued     <= r_queued;
            r_res.released   <= r_released;
        end
    end

endmodule

>>> src/frame_deferred_release_queue.sv
// Channel  Dir  Handshake          Payload
// s_axis   in   tvalid/tready      tuser: op; tdata: handle, res_type, frame
// m_axis   out  tvalid/tready      tuser: is_release; tlast: last; tdata: results
// cfg      in   we (no wait)       idx 0 defer_frames, idx 1 capacity_limit
//
// Queue, clear and unused codes go straight to the final result. Count and lookup walk
// the pending entries once, flush walks them once releasing each; the entry RAM gives
// one read per cycle, and collect walks it twice (count, then release).
// Output stalls hold the walk; a finished result waits in the output register.
// Reset (synchronous, active low) clears counters and control; no RAM sweep.
// Top level: configuration registers, stream packing; uses dfrq_pkg, dfrq_ram, dfrq_seq.
module frame_deferred_release_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [103:0]  i_s_axis_tdata,   // handle[63:0], res_type[71:64], frame[103:72]
    input  logic [2:0]    i_s_axis_tuser,   // op[2:0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [151:0]  o_m_axis_tdata,   // released_handle[63:0], flag[64], count[70:65],
                                            // pending_now[76:71], peak_now[82:77],
                                            // queued_total[114:83], released_total[146:115]
    output logic [0:0]    o_m_axis_tuser,   // is_release[0]
    output logic          o_m_axis_tlast,   // last
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    import dfrq_pkg::*;

    t_cfg              r_cfg;
    t_mem_wr           mem_wr;
    logic [ADDR_W-1:0] mem_raddr;
    t_entry            mem_rdata;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.defer <= FRM_W'(2);
            r_cfg.cap   <= CNT_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEFER: r_cfg.defer <= i_cfg_data;
                CFG_CAP:   r_cfg.cap   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dfrq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.we),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dfrq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_handle    (i_s_axis_tdata[63:0]),
        .i_res_type  (i_s_axis_tdata[71:64]),
        .i_frame     (i_s_axis_tdata[103:72]),
        .o_mem_wr    (mem_wr),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tuser = res.is_release;
    assign o_m_axis_tlast = res.last;
    assign o_m_axis_tdata = {5'd0, res.released, res.queued, res.peak, res.pending,
                             res.count, res.flag, res.handle};

endmodule
